[hw/rtl/salc_pkg.sv]
// shared types and constants of the lru cache tag store
package salc_pkg;

  localparam int AddrW    = 32;
  localparam int StampW   = 32;
  localparam int MissW    = 32;
  localparam int WayOutW  = 3;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 5;
  localparam int SbitsW   = 4;
  localparam int WaysW    = 4;
  localparam int OffW     = 5;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgSetIndexBits = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgWaysInUse    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgOffsetBits   = 2'd2;

  typedef struct packed {
    logic              valid;
    logic [AddrW-1:0]  tag;
    logic [StampW-1:0] stamp;
  } line_t;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StPrep,
    StScan,
    StWrite
  } salc_state_e;

endpackage

[hw/rtl/salc_ram.sv]
// generic simple dual-port ram with registered read
module salc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/set_assoc_lru_cache_tags_top.sv]
// top level of the set-associative lru cache tag store
//
//  channel | signals                                           | direction
//  --------+---------------------------------------------------+----------
//  cfg     | cfg_valid_i cfg_ready_o cfg_index_i cfg_data_i     | in
//  in      | in_valid_i in_ready_o address_i                    | in
//  out     | out_valid_o out_ready_i hit_o way_used_o           | out
//          | evicted_o miss_total_o                             |
//
// a lookup splits the address into set and tag, then streams one tag ram
// read per way through a single tag and stamp comparator, the ram read
// being registered, and stops at a hit at way w or after the n ways in use
// on a miss; it then writes the line back, and the next word is taken in
// the cycle after the result is loaded
// after reset a clearing pass writes every line of the tag ram, one a cycle,
// with in_ready_o low; config writes are taken
// the write-back cycle holds while the previous result has not been taken
module set_assoc_lru_cache_tags_top #(
  parameter int MAX_SETS = 256,
  parameter int MAX_WAYS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write port
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [salc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [salc_pkg::CfgDataW-1:0] cfg_data_i,
  // access words
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [salc_pkg::AddrW-1:0]    address_i,
  // lookup results
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hit_o,
  output logic [salc_pkg::WayOutW-1:0]  way_used_o,
  output logic                          evicted_o,
  output logic [salc_pkg::MissW-1:0]    miss_total_o
);
  import salc_pkg::*;

  localparam int Lines   = MAX_SETS * MAX_WAYS;
  localparam int LineAw  = (Lines > 1) ? $clog2(Lines) : 1;
  // floor(log2(MAX_SETS)): widest set index in use
  localparam int SetCap  = $clog2(MAX_SETS + 1) - 1;
  localparam int SetW    = (SetCap > 0) ? SetCap : 1;
  localparam int WayIw   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WayCntW = $clog2(MAX_WAYS + 1);

  salc_state_e state_q, state_d;

  logic [LineAw-1:0]  clr_q, clr_d;
  logic [SbitsW-1:0]  cfg_sbits_q;
  logic [WaysW-1:0]   cfg_ways_q;
  logic [OffW-1:0]    cfg_off_q;

  logic [AddrW-1:0]   addr_q, addr_d;
  logic [AddrW-1:0]   tag_q, tag_d;
  logic [LineAw-1:0]  base_q, base_d;
  logic [WayCntW-1:0] rd_way_q, rd_way_d;
  logic               cmp_vld_q, cmp_vld_d;
  logic [WayIw-1:0]   cmp_way_q, cmp_way_d;
  logic               inv_fnd_q, inv_fnd_d;
  logic [WayIw-1:0]   inv_way_q, inv_way_d;
  logic [StampW-1:0]  old_stamp_q, old_stamp_d;
  logic [WayIw-1:0]   old_way_q, old_way_d;
  logic [WayIw-1:0]   pick_q, pick_d;
  logic               res_hit_q, res_hit_d;
  logic               res_evict_q, res_evict_d;
  logic [StampW-1:0]  clock_q, clock_d;
  logic [MissW-1:0]   miss_q, miss_d;

  logic               out_vld_q, out_vld_d;
  logic               out_hit_q;
  logic [WayOutW-1:0] out_way_q;
  logic               out_evict_q;
  logic [MissW-1:0]   out_miss_q;
  logic               load_out;

  // effective configuration, saturated
  logic [4:0]         sbits_eff;
  logic [WayCntW-1:0] ways_eff;

  // tag ram port signals
  logic               ram_we;
  logic [LineAw-1:0]  ram_waddr;
  line_t              ram_wdata;
  logic [LineAw-1:0]  ram_raddr;
  logic [$bits(line_t)-1:0] ram_rdata;

  salc_ram #(
    .Width ($bits(line_t)),
    .Depth (Lines)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // config registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_sbits_q <= SbitsW'(8);
      cfg_ways_q  <= WaysW'(8);
      cfg_off_q   <= OffW'(6);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgSetIndexBits: cfg_sbits_q <= cfg_data_i[SbitsW-1:0];
        CfgWaysInUse:    cfg_ways_q  <= cfg_data_i[WaysW-1:0];
        CfgOffsetBits:   cfg_off_q   <= cfg_data_i[OffW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (int'(cfg_sbits_q) > SetCap) begin
      sbits_eff = 5'(SetCap);
    end else begin
      sbits_eff = 5'(cfg_sbits_q);
    end
    if (cfg_ways_q == '0) begin
      ways_eff = WayCntW'(1);
    end else if (int'(cfg_ways_q) > MAX_WAYS) begin
      ways_eff = WayCntW'(MAX_WAYS);
    end else begin
      ways_eff = WayCntW'(cfg_ways_q);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StClear;
      clr_q     <= '0;
      cmp_vld_q <= 1'b0;
      clock_q   <= '0;
      miss_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      cmp_vld_q <= cmp_vld_d;
      clock_q   <= clock_d;
      miss_q    <= miss_d;
      out_vld_q <= out_vld_d;
    end
  end

  // lookup datapath registers
  always_ff @(posedge clk_i) begin
    addr_q      <= addr_d;
    tag_q       <= tag_d;
    base_q      <= base_d;
    rd_way_q    <= rd_way_d;
    cmp_way_q   <= cmp_way_d;
    inv_fnd_q   <= inv_fnd_d;
    inv_way_q   <= inv_way_d;
    old_stamp_q <= old_stamp_d;
    old_way_q   <= old_way_d;
    pick_q      <= pick_d;
    res_hit_q   <= res_hit_d;
    res_evict_q <= res_evict_d;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_hit_q   <= res_hit_q;
      out_way_q   <= WayOutW'(pick_q);
      out_evict_q <= res_evict_q;
      out_miss_q  <= miss_q;
    end
  end

  // ram read streams one way per cycle during the scan
  assign ram_raddr = base_q + LineAw'(rd_way_q);

  always_comb begin
    line_t             rd_line;
    logic [AddrW-1:0]  blk_v;
    logic [SetW-1:0]   mask_v;
    logic [SetW-1:0]   set_v;
    logic [31:0]       prod_v;
    logic [5:0]        sh_v;
    logic              is_hit;
    logic              last_v;

    state_d     = state_q;
    clr_d       = clr_q;
    addr_d      = addr_q;
    tag_d       = tag_q;
    base_d      = base_q;
    rd_way_d    = rd_way_q;
    cmp_vld_d   = 1'b0;
    cmp_way_d   = cmp_way_q;
    inv_fnd_d   = inv_fnd_q;
    inv_way_d   = inv_way_q;
    old_stamp_d = old_stamp_q;
    old_way_d   = old_way_q;
    pick_d      = pick_q;
    res_hit_d   = res_hit_q;
    res_evict_d = res_evict_q;
    clock_d     = clock_q;
    miss_d      = miss_q;
    out_vld_d   = out_vld_q && !out_ready_i;
    load_out    = 1'b0;
    in_ready_o  = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = clr_q;
    ram_wdata   = '0;

    rd_line = line_t'(ram_rdata);
    blk_v   = '0;
    mask_v  = '0;
    set_v   = '0;
    prod_v  = '0;
    sh_v    = '0;
    is_hit  = 1'b0;
    last_v  = 1'b0;

    case (state_q)
      StClear: begin
        // invalidate every line after reset
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == LineAw'(Lines - 1)) begin
          state_d = StIdle;
        end
      end

      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          addr_d  = address_i;
          state_d = StPrep;
        end
      end

      StPrep: begin
        // split address into set and tag
        blk_v = addr_q >> cfg_off_q;
        for (int i = 0; i < SetW; i++) begin
          mask_v[i] = (i < int'(sbits_eff));
        end
        set_v     = blk_v[SetW-1:0] & mask_v;
        prod_v    = 32'(set_v) * 32'(MAX_WAYS);
        base_d    = prod_v[LineAw-1:0];
        sh_v      = 6'(cfg_off_q) + 6'(sbits_eff);
        tag_d     = addr_q >> sh_v;
        rd_way_d  = '0;
        inv_fnd_d = 1'b0;
        state_d   = StScan;
      end

      StScan: begin
        // issue the read of the next way
        if (rd_way_q < ways_eff) begin
          rd_way_d  = rd_way_q + 1'b1;
          cmp_vld_d = 1'b1;
          cmp_way_d = WayIw'(rd_way_q);
        end
        // compare the way read last cycle
        if (cmp_vld_q) begin
          is_hit = rd_line.valid && (rd_line.tag == tag_q);
          last_v = (WayCntW'(cmp_way_q) == (ways_eff - WayCntW'(1)));
          if (!rd_line.valid && !inv_fnd_q) begin
            inv_fnd_d = 1'b1;
            inv_way_d = cmp_way_q;
          end
          // strict less keeps the lowest way on equal stamps
          if (rd_line.valid &&
              ((cmp_way_q == '0) || (rd_line.stamp < old_stamp_q))) begin
            old_stamp_d = rd_line.stamp;
            old_way_d   = cmp_way_q;
          end
          if (is_hit) begin
            cmp_vld_d   = 1'b0;
            pick_d      = cmp_way_q;
            res_hit_d   = 1'b1;
            res_evict_d = 1'b0;
            state_d     = StWrite;
          end else if (last_v) begin
            cmp_vld_d = 1'b0;
            miss_d    = miss_q + 1'b1;
            res_hit_d = 1'b0;
            if (inv_fnd_d) begin
              pick_d      = inv_way_d;
              res_evict_d = 1'b0;
            end else begin
              pick_d      = old_way_d;
              res_evict_d = 1'b1;
            end
            state_d = StWrite;
          end
        end
      end

      StWrite: begin
        // write back valid line with fresh stamp, repeated while stalled
        ram_we          = 1'b1;
        ram_waddr       = base_q + LineAw'(pick_q);
        ram_wdata.valid = 1'b1;
        ram_wdata.tag   = tag_q;
        ram_wdata.stamp = clock_q;
        if (!out_vld_q || out_ready_i) begin
          load_out  = 1'b1;
          out_vld_d = 1'b1;
          clock_d   = clock_q + 1'b1;
          state_d   = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign out_valid_o  = out_vld_q;
  assign hit_o        = out_hit_q;
  assign way_used_o   = out_way_q;
  assign evicted_o    = out_evict_q;
  assign miss_total_o = out_miss_q;

endmodule

[hw/rtl/salc_checker.sv]
// port-level checks of the lru cache tag store and their bind
module salc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic                         hit_o,
  input logic [salc_pkg::WayOutW-1:0] way_used_o,
  input logic                         evicted_o,
  input logic [salc_pkg::MissW-1:0]   miss_total_o
);
  import salc_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hit_o) &&
      $stable(way_used_o) && $stable(evicted_o) && $stable(miss_total_o))
    else $error("result changed while stalled");

  // one word at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after accepting a word");

  // a fresh result only comes out of a lookup in progress
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without a lookup");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> !evicted_o)
    else $error("hit reported with eviction");

endmodule

bind set_assoc_lru_cache_tags_top salc_checker u_salc_checker (.*);

[tb/sv/lru_tag_checker.sv]
// shadow tag store and result compare for the lru cache tag store
`timescale 1ns / 100ps
module lru_tag_checker #(
  parameter int MAX_SETS = 256,
  parameter int MAX_WAYS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_o,
  input  logic [salc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [salc_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_o,
  input  logic [salc_pkg::AddrW-1:0]    address_i,
  input  logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  logic                          hit_o,
  input  logic [salc_pkg::WayOutW-1:0]  way_used_o,
  input  logic                          evicted_o,
  input  logic [salc_pkg::MissW-1:0]    miss_total_o,
  output int                            mismatch_o,
  output int                            pending_o
);
  import salc_pkg::*;

  localparam int LineCount  = MAX_SETS * MAX_WAYS;
  localparam int SetBitsCap = $clog2(MAX_SETS + 1) - 1;
  localparam int MaxReports = 100;

  typedef struct packed {
    logic               hit;
    logic [WayOutW-1:0] way;
    logic               evicted;
    logic [MissW-1:0]   miss_total;
  } lookup_t;

  logic [SbitsW-1:0] set_bits_q;
  logic [WaysW-1:0]  ways_q;
  logic [OffW-1:0]   offset_q;

  bit                line_live    [LineCount];
  logic [AddrW-1:0]  line_tag     [LineCount];
  logic [StampW-1:0] line_used_at [LineCount];
  logic [StampW-1:0] access_count;
  logic [MissW-1:0]  miss_count;

  lookup_t expected_lookups [$];
  lookup_t want;

  // one access against the shadow store, updating it as the block should
  function automatic lookup_t predict_lookup(input logic [AddrW-1:0] addr);
    int unsigned sb, nways, base, pick;
    logic [63:0] wide;
    logic [AddrW-1:0] tag;
    logic [StampW-1:0] oldest;
    bit done;
    lookup_t r;
    sb = (set_bits_q > SetBitsCap) ? SetBitsCap : set_bits_q;
    nways = (ways_q == 0) ? 1 : ((ways_q > MAX_WAYS) ? MAX_WAYS : ways_q);
    wide = {32'd0, addr};
    base = int'((wide >> offset_q) & ((64'd1 << sb) - 64'd1)) * MAX_WAYS;
    tag = AddrW'(wide >> (offset_q + sb));
    pick = 0;
    done = 0;
    r = '0;
    for (int w = 0; w < nways && !done; w++) begin
      if (line_live[base + w] && line_tag[base + w] == tag) begin
        line_used_at[base + w] = access_count;
        r.hit = 1'b1;
        pick = w;
        done = 1;
      end
    end
    if (!done) begin
      miss_count++;
      for (int w = 0; w < nways && !done; w++) begin
        if (!line_live[base + w]) begin
          line_live[base + w] = 1;
          line_tag[base + w] = tag;
          line_used_at[base + w] = access_count;
          pick = w;
          done = 1;
        end
      end
    end
    // all ways valid: oldest stamp goes, lowest way wins a tie
    if (!done) begin
      oldest = line_used_at[base];
      pick = 0;
      for (int w = 1; w < nways; w++) begin
        if (line_used_at[base + w] < oldest) begin
          oldest = line_used_at[base + w];
          pick = w;
        end
      end
      line_tag[base + pick] = tag;
      line_used_at[base + pick] = access_count;
      r.evicted = 1'b1;
    end
    access_count++;
    r.way = WayOutW'(pick);
    r.miss_total = miss_count;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [63:0] exp_v, act_v);
    if (act_v !== exp_v) begin
      mismatch_o++;
      if (mismatch_o <= MaxReports)
        $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LineCount; i++) begin
        line_live[i] = 0;
        line_tag[i] = '0;
        line_used_at[i] = '0;
      end
      access_count = '0;
      miss_count = '0;
      set_bits_q = 4'd8;
      ways_q = 4'd8;
      offset_q = 5'd6;
      expected_lookups.delete();
      mismatch_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgSetIndexBits: set_bits_q = cfg_data_i[SbitsW-1:0];
          CfgWaysInUse:    ways_q = cfg_data_i[WaysW-1:0];
          CfgOffsetBits:   offset_q = cfg_data_i[OffW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o)
        expected_lookups.push_back(predict_lookup(address_i));
      if (out_valid_o === 1'b1 && out_ready_i) begin
        if (expected_lookups.size() == 0) begin
          mismatch_o++;
          if (mismatch_o <= MaxReports)
            $error("result word with no lookup pending: hit %0d way %0d", hit_o, way_used_o);
        end else begin
          want = expected_lookups.pop_front();
          compare_field("hit", want.hit, hit_o);
          compare_field("way_used", want.way, way_used_o);
          compare_field("evicted", want.evicted, evicted_o);
          compare_field("miss_total", want.miss_total, miss_total_o);
        end
      end
      pending_o = expected_lookups.size();
    end
  end

endmodule

[tb/sv/set_assoc_lru_cache_tags_top_tb.sv]
// testbench top for the lru cache tag store: stimulus, handshakes and verdict
`timescale 1ns / 100ps
module set_assoc_lru_cache_tags_top_tb;
  import salc_pkg::*;

  localparam int MAX_SETS      = 256;
  localparam int MAX_WAYS      = 8;
  localparam int SetBitsCap    = $clog2(MAX_SETS + 1) - 1;
  localparam int NumSettings   = 7;
  localparam int WordsPerPhase = 38;
  localparam int HoldCycles    = 300;
  // index past the register list, the block must ignore it
  localparam logic [CfgIdxW-1:0] CfgUnmapped = 2'd3;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = CfgSetIndexBits;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [AddrW-1:0]    address_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                hit_o;
  logic [WayOutW-1:0]  way_used_o;
  logic                evicted_o;
  logic [MissW-1:0]    miss_total_o;

  int lookup_errors;
  int pending_lookups;

  // idling knobs, in percent per cycle
  int idle_pct = 0;
  int stall_pct = 0;

  // long receiver hold-off, kicked by the stimulus and counted by the receiver
  int hold_kicks = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // stimulus-side view of the settings, only used to shape addresses
  logic [SbitsW-1:0] cur_sbits = 4'd8;
  logic [WaysW-1:0]  cur_ways = 4'd8;
  logic [OffW-1:0]   cur_off = 5'd6;
  logic [AddrW-1:0]  tag_base = '0;

  always #10 clk_i = ~clk_i;

  set_assoc_lru_cache_tags_top #(
    .MAX_SETS(MAX_SETS),
    .MAX_WAYS(MAX_WAYS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .address_i    (address_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hit_o        (hit_o),
    .way_used_o   (way_used_o),
    .evicted_o    (evicted_o),
    .miss_total_o (miss_total_o)
  );

  lru_tag_checker #(
    .MAX_SETS(MAX_SETS),
    .MAX_WAYS(MAX_WAYS)
  ) lookup_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .address_i    (address_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hit_o        (hit_o),
    .way_used_o   (way_used_o),
    .evicted_o    (evicted_o),
    .miss_total_o (miss_total_o),
    .mismatch_o   (lookup_errors),
    .pending_o    (pending_lookups)
  );

  // result side: random stalls, or a long hold-off when one is kicked
  always @(negedge clk_i) begin
    if (hold_seen != hold_kicks) begin
      hold_seen = hold_kicks;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // offer one access word, called and returning at a falling edge; valid is
  // left high so back-to-back words need no drop in between
  task automatic send_word(input logic [AddrW-1:0] addr);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    address_i <= addr;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    @(negedge clk_i);
  endtask

  // one register write; the caller drops cfg valid after the last one
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    @(negedge clk_i);
  endtask

  // stop offering, let every pending result come back, then a few quiet
  // cycles so the write-back of the last word is surely done
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_lookups != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  // mostly a small pool of tags over a few sets, so that hits, fills and
  // lru evictions all happen; the rest is a fully random address
  function automatic logic [AddrW-1:0] pick_address();
    int unsigned sb, nw, tag_idx, set_idx;
    logic [63:0] a;
    if ($urandom_range(99) < 15) return $urandom();
    sb = (cur_sbits > SetBitsCap) ? SetBitsCap : cur_sbits;
    nw = (cur_ways == 0) ? 1 : ((cur_ways > MAX_WAYS) ? MAX_WAYS : cur_ways);
    tag_idx = $urandom_range(nw + 2);
    set_idx = $urandom_range(3) & ((1 << sb) - 1);
    a = ({32'd0, tag_base ^ tag_idx} << (cur_off + sb))
      | ({32'd0, set_idx} << cur_off)
      | ({32'd0, $urandom()} & ((64'd1 << cur_off) - 64'd1));
    return a[AddrW-1:0];
  endfunction

  // run limit, far beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    logic [CfgDataW-1:0] sb_d, wy_d, off_d;
    logic [AddrW-1:0] directed_addrs [$];
    // reset settings: 256 sets, 8 ways, 64-byte blocks, so tag starts at bit 14
    directed_addrs = {
      32'h0000_0000, 32'h0000_0000,             // cold miss, then hit
      32'hFFFF_FFFF, 32'hFFFF_FFFF,             // top set, all-ones tag
      32'h0000_4000, 32'h0000_8000, 32'h0000_C000, 32'h0001_0000,
      32'h0001_4000, 32'h0001_8000, 32'h0001_C000, // fill set 0
      32'h0002_0000,                            // set 0 full: evicts tag 0
      32'h0000_C000,                            // hit refreshes tag 3
      32'h0002_4000,                            // evicts tag 1, the oldest now
      32'h0000_0000,                            // old tag back, evicts again
      32'h8000_0000, 32'h7FFF_FFFF,             // single high bit and its inverse
      32'h0000_0040, 32'h0000_003F              // next set, same block as 0
    };

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // words wait out the clearing pass on in_ready
    foreach (directed_addrs[i]) send_word(directed_addrs[i]);

    for (int k = 0; k < NumSettings; k++) begin
      settle();
      // extremes first: one set direct mapped, then every saturation at once
      case (k)
        0: begin sb_d = 5'd0;  wy_d = 5'd1;  off_d = 5'd0;  end
        1: begin sb_d = 5'd31; wy_d = 5'd0;  off_d = 5'd31; end
        2: begin sb_d = 5'd8;  wy_d = 5'd31; off_d = 5'd16; end
        3: begin sb_d = 5'd2;  wy_d = 5'd4;  off_d = 5'd4;  end
        4: begin sb_d = 5'd3;  wy_d = 5'd8;  off_d = 5'd12; end
        5: begin sb_d = 5'd1;  wy_d = 5'd2;  off_d = 5'd20; end
        default: begin sb_d = 5'd8; wy_d = 5'd8; off_d = 5'd6; end
      endcase
      write_reg(CfgSetIndexBits, sb_d);
      write_reg(CfgWaysInUse, wy_d);
      write_reg(CfgOffsetBits, off_d);
      if (k == 1) write_reg(CfgUnmapped, 5'h1F);
      cfg_valid_i <= 1'b0;
      cur_sbits = sb_d[SbitsW-1:0];
      cur_ways = wy_d[WaysW-1:0];
      cur_off = off_d[OffW-1:0];
      tag_base = $urandom();

      for (int m = 0; m < 4; m++) begin
        // no idling, sparse sender, stalling receiver, light noise on both
        case (m)
          0: begin idle_pct = 0;  stall_pct = 0;  end
          1: begin idle_pct = 88; stall_pct = 0;  end
          2: begin idle_pct = 0;  stall_pct = 88; end
          default: begin idle_pct = 8; stall_pct = 8; end
        endcase
        // receiver holds off while words keep coming, so the block backs up
        if (k == 2 && m == 0) begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          hold_kicks++;
          @(negedge clk_i);
        end
        for (int i = 0; i < WordsPerPhase; i++) begin
          // sender goes quiet until every result is back, mid-stream
          if (k == 4 && m == 1 && i == WordsPerPhase / 2) settle();
          send_word(pick_address());
        end
      end
    end

    settle();
    repeat (14) @(negedge clk_i);
    if (lookup_errors == 0 && pending_lookups == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
